// ===== rtl/trs_pkg.sv =====
package trs_pkg;

   // Field and register widths
   localparam int unsigned NumAxes       = 4;
   localparam int unsigned NumDimsWidth  = 3;
   localparam int unsigned AxisWidth     = 2;
   localparam int unsigned DimWidth      = 9;
   localparam int unsigned BatchIdxWidth = 8;
   localparam int unsigned LenWidth      = 9;
   localparam int unsigned ValueWidth    = 16;
   localparam int unsigned DestWidth     = 32;
   localparam int unsigned AddrWidth     = 5;
   localparam int unsigned DataWidth     = 32;

   // Dimension count limits
   localparam logic [NumDimsWidth-1:0] MinDims = 3'd2;
   localparam logic [NumDimsWidth-1:0] MaxDims = 3'd4;

   // Register reset values
   localparam logic [NumDimsWidth-1:0] NumDimsReset  = 3'd4;
   localparam logic [AxisWidth-1:0]    BatchDimReset = 2'd0;
   localparam logic [AxisWidth-1:0]    SeqDimReset   = 2'd1;
   localparam logic [DimWidth-1:0]     DimSizeReset  = 9'd1;

   // Register index, address bits [4:2]
   typedef enum logic [2:0] {
      REG_NUM_DIMS  = 3'd0,
      REG_BATCH_DIM = 3'd1,
      REG_SEQ_DIM   = 3'd2,
      REG_DIM_SIZE0 = 3'd3,
      REG_DIM_SIZE1 = 3'd4,
      REG_DIM_SIZE2 = 3'd5,
      REG_DIM_SIZE3 = 3'd6
   } reg_index_type;

   // Input word command
   typedef enum logic {
      CMD_STORE_LEN = 1'b0,
      CMD_ELEMENT   = 1'b1
   } command_type;

   typedef logic [DimWidth-1:0] dim_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [NumDimsWidth-1:0]  num_dims;
      logic [AxisWidth-1:0]     batch_dim;
      logic [AxisWidth-1:0]     seq_dim;
      dim_type [NumAxes-1:0]    dim_size;
   } cfg_type;

endpackage

// ===== rtl/tensor_reverse_sequence_remap.sv =====
// Reverse-sequence index remapper for fp16 tensors of two to four axes.
// Request channel (req_*): a word with command CMD_STORE_LEN writes
// seq_length into the per-batch length table at batch_index; a word with
// command CMD_ELEMENT is one tensor element, sent in dense order with
// axis 0 innermost. Response channel (rsp_*): one word per element with its
// dense destination index, the unchanged fp16 bits and last on the final
// element; length stores give no response.
// Both channels use valid/ready. rsp_valid is registered; an accepted element
// passes the five-stage pipeline (length table read, coordinate mirror, two
// multiply stages, final add) with one word of storage per stage, so one
// word is accepted every cycle while the response side does not stall.
// A stalled receiver fills the pipeline stages behind it; req_ready drops
// only when every stage holds a word. The APB port sets axis count, batch
// and sequence axes and axis sizes; write it only between tensors with
// the pipeline empty.
// Reset clears the configuration to its defaults, the coordinate counters
// and the pipeline. The length table is not cleared: write every batch's
// length before streaming elements that use it.
module tensor_reverse_sequence_remap #(
   parameter int unsigned MAX_BATCH = 256,
   parameter int unsigned MAX_DIM   = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [trs_pkg::BatchIdxWidth-1:0]     req_batch_index,
   input  logic [trs_pkg::LenWidth-1:0]          req_seq_length,
   input  logic [trs_pkg::ValueWidth-1:0]        req_elem_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [trs_pkg::DestWidth-1:0]         rsp_dest_index,
   output logic [trs_pkg::ValueWidth-1:0]        rsp_out_value,
   output logic                                  rsp_last,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [trs_pkg::AddrWidth-1:0]         paddr,
   input  logic [trs_pkg::DataWidth-1:0]         pwdata,
   output logic [trs_pkg::DataWidth-1:0]         prdata,
   output logic                                  pready
);

   localparam int unsigned NA   = trs_pkg::NumAxes;
   localparam int unsigned CW   = $clog2(MAX_DIM);
   localparam int unsigned XW   = CW + 1;
   localparam int unsigned SW   = $clog2(MAX_DIM + 1);
   localparam int unsigned LW   = trs_pkg::LenWidth;
   localparam int unsigned CLW  = (SW > LW) ? SW : LW;
   localparam int unsigned BAW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int unsigned DW   = trs_pkg::DestWidth;
   localparam int unsigned VW   = trs_pkg::ValueWidth;
   localparam int unsigned P1W  = CW + SW;
   localparam int unsigned P2W  = 2 * SW;
   localparam int unsigned P3W  = 2 * SW + CW;
   localparam int unsigned S3W  = 3 * SW;
   localparam int unsigned P4W  = DW + CW;

   trs_pkg::cfg_type cfg;

   logic [trs_pkg::NumDimsWidth-1:0] nd;
   logic [NA-1:0][SW-1:0]            size;
   logic                             reverse;
   logic                             batch_in_range;

   logic [NA-1:0][CW-1:0] coord_ff;
   logic [NA-1:0][CW-1:0] coord_in;
   logic                  wrap_all;

   logic            req_accept;
   logic            elem_accept;
   logic            store_accept;
   logic            tbl_wr_en;
   logic [31:0]     tbl_wr_wide;
   logic [CW-1:0]   batch_coord;
   logic [31:0]     batch_wide;
   logic [LW-1:0]   tbl_rd_data;

   // stage 1: counters snapshot, table read in flight
   logic                  s1_valid_ff;
   logic                  s1_ready;
   logic [NA-1:0][CW-1:0] s1_coord_ff;
   logic [VW-1:0]         s1_value_ff;
   logic                  s1_last_ff;
   logic                  s1_oob_ff;

   // stage 2: mirrored coordinates
   logic                  s2_valid_ff;
   logic                  s2_ready;
   logic [NA-1:0][CW-1:0] s2_coord_ff;
   logic [NA-1:0][CW-1:0] s2_coord_in;
   logic [VW-1:0]         s2_value_ff;
   logic                  s2_last_ff;
   logic [P2W-1:0]        s2_stride2_ff;
   logic [LW-1:0]         len_raw;
   logic [SW-1:0]         seq_size;
   logic [CLW-1:0]        len_clamp;
   logic [CW-1:0]         seq_coord;
   logic [CLW-1:0]        mirror;

   // stage 3: first products
   logic            s3_valid_ff;
   logic            s3_ready;
   logic [CW-1:0]   s3_c0_ff;
   logic [CW-1:0]   s3_c3_ff;
   logic [P1W-1:0]  s3_p1_ff;
   logic [DW-1:0]   s3_p2_ff;
   logic [DW-1:0]   s3_stride3_ff;
   logic [VW-1:0]   s3_value_ff;
   logic            s3_last_ff;

   // stage 4: outer product and partial sum
   logic            s4_valid_ff;
   logic            s4_ready;
   logic [DW-1:0]   s4_p3_ff;
   logic [DW-1:0]   s4_sum_ff;
   logic [VW-1:0]   s4_value_ff;
   logic            s4_last_ff;

   // response register
   logic            rsp_valid_ff;
   logic            out_ready;
   logic [DW-1:0]   rsp_dest_ff;
   logic [VW-1:0]   rsp_value_ff;
   logic            rsp_last_ff;

   trs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Clamp the axis count
   always_comb begin
      if (cfg.num_dims < trs_pkg::MinDims) begin
         nd = trs_pkg::MinDims;
      end else if (cfg.num_dims > trs_pkg::MaxDims) begin
         nd = trs_pkg::MaxDims;
      end else begin
         nd = cfg.num_dims;
      end
   end

   // Effective axis sizes: unused axes and zero act as one
   always_comb begin
      for (int ax = 0; ax < NA; ax++) begin
         if (3'(ax) >= nd || cfg.dim_size[ax] == '0) begin
            size[ax] = SW'(1);
         end else if (32'(cfg.dim_size[ax]) > MAX_DIM) begin
            size[ax] = SW'(MAX_DIM);
         end else begin
            size[ax] = SW'(cfg.dim_size[ax]);
         end
      end
   end

   assign reverse        = {1'b0, cfg.seq_dim} < nd;
   assign batch_in_range = {1'b0, cfg.batch_dim} < nd;

   // Handshake chain, one word per stage
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign req_accept   = req_valid && req_ready;
   assign elem_accept  = req_accept && (req_command == trs_pkg::CMD_ELEMENT);
   assign store_accept = req_accept && (req_command == trs_pkg::CMD_STORE_LEN);

   // Advance the coordinate counters with carry
   always_comb begin
      wrap_all = 1'b1;
      for (int ax = 0; ax < NA; ax++) begin
         coord_in[ax] = coord_ff[ax];
         if (wrap_all) begin
            if (XW'(coord_ff[ax]) + XW'(1) >= XW'(size[ax])) begin
               coord_in[ax] = '0;
            end else begin
               coord_in[ax] = coord_ff[ax] + CW'(1);
               wrap_all     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff <= '0;
      end else if (elem_accept) begin
         coord_ff <= coord_in;
      end
   end

   // Length table: store on length words, read at the batch coordinate
   assign tbl_wr_wide = 32'(req_batch_index);
   assign tbl_wr_en   = store_accept && (tbl_wr_wide < MAX_BATCH);
   assign batch_coord = batch_in_range ? coord_ff[cfg.batch_dim] : '0;
   assign batch_wide  = 32'(batch_coord);

   trs_ram #(
      .Width (LW),
      .Depth (MAX_BATCH)
   ) u_length_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_wide[BAW-1:0]),
      .wr_data (req_seq_length),
      .rd_en   (elem_accept),
      .rd_addr (batch_wide[BAW-1:0]),
      .rd_data (tbl_rd_data)
   );

   // Stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= elem_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (elem_accept) begin
         s1_coord_ff <= coord_ff;
         s1_value_ff <= req_elem_value;
         s1_last_ff  <= wrap_all;
         s1_oob_ff   <= batch_wide >= MAX_BATCH;
      end
   end

   // Clamp the length and mirror the sequence coordinate
   always_comb begin
      len_raw  = s1_oob_ff ? '0 : tbl_rd_data;
      seq_size = size[cfg.seq_dim];
      if (CLW'(len_raw) > CLW'(seq_size)) begin
         len_clamp = CLW'(seq_size);
      end else begin
         len_clamp = CLW'(len_raw);
      end
      seq_coord   = s1_coord_ff[cfg.seq_dim];
      mirror      = len_clamp - CLW'(1) - CLW'(seq_coord);
      s2_coord_in = s1_coord_ff;
      if (reverse && (CLW'(seq_coord) < len_clamp)) begin
         s2_coord_in[cfg.seq_dim] = mirror[CW-1:0];
      end
   end

   // Stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_coord_ff   <= s2_coord_in;
         s2_value_ff   <= s1_value_ff;
         s2_last_ff    <= s1_last_ff;
         s2_stride2_ff <= P2W'(size[0]) * P2W'(size[1]);
      end
   end

   // Stage 3: axis 1 and axis 2 terms, axis 3 stride
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_c0_ff      <= s2_coord_ff[0];
         s3_c3_ff      <= s2_coord_ff[3];
         s3_p1_ff      <= P1W'(s2_coord_ff[1]) * P1W'(size[0]);
         s3_p2_ff      <= DW'(P3W'(s2_coord_ff[2]) * P3W'(s2_stride2_ff));
         s3_stride3_ff <= DW'(S3W'(s2_stride2_ff) * S3W'(size[2]));
         s3_value_ff   <= s2_value_ff;
         s3_last_ff    <= s2_last_ff;
      end
   end

   // Stage 4: axis 3 term and sum of the inner terms
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_p3_ff    <= DW'(P4W'(s3_c3_ff) * P4W'(s3_stride3_ff));
         s4_sum_ff   <= DW'(s3_c0_ff) + DW'(s3_p1_ff) + s3_p2_ff;
         s4_value_ff <= s3_value_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   // Response register; hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_dest_ff  <= s4_sum_ff + s4_p3_ff;
         rsp_value_ff <= s4_value_ff;
         rsp_last_ff  <= s4_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_index = rsp_dest_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== rtl/trs_ram.sv =====
module trs_ram #(
   parameter int unsigned Width     = 9,
   parameter int unsigned Depth     = 256,
   parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold the last word while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/trs_csr.sv =====
module trs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [trs_pkg::AddrWidth-1:0]       paddr,
   input  logic [trs_pkg::DataWidth-1:0]       pwdata,
   output logic [trs_pkg::DataWidth-1:0]       prdata,
   output logic                                pready,
   output trs_pkg::cfg_type                    cfg
);

   localparam int unsigned DataW = trs_pkg::DataWidth;

   logic [trs_pkg::NumDimsWidth-1:0]          num_dims_ff;
   logic [trs_pkg::AxisWidth-1:0]             batch_dim_ff;
   logic [trs_pkg::AxisWidth-1:0]             seq_dim_ff;
   trs_pkg::dim_type [trs_pkg::NumAxes-1:0]   dim_size_ff;

   trs_pkg::reg_index_type index;
   logic                   wr_en;

   assign index  = trs_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register write; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff  <= trs_pkg::NumDimsReset;
         batch_dim_ff <= trs_pkg::BatchDimReset;
         seq_dim_ff   <= trs_pkg::SeqDimReset;
         dim_size_ff  <= {trs_pkg::NumAxes{trs_pkg::DimSizeReset}};
      end else if (wr_en) begin
         unique case (index)
            trs_pkg::REG_NUM_DIMS:  num_dims_ff    <= pwdata[2:0];
            trs_pkg::REG_BATCH_DIM: batch_dim_ff   <= pwdata[1:0];
            trs_pkg::REG_SEQ_DIM:   seq_dim_ff     <= pwdata[1:0];
            trs_pkg::REG_DIM_SIZE0: dim_size_ff[0] <= pwdata[8:0];
            trs_pkg::REG_DIM_SIZE1: dim_size_ff[1] <= pwdata[8:0];
            trs_pkg::REG_DIM_SIZE2: dim_size_ff[2] <= pwdata[8:0];
            trs_pkg::REG_DIM_SIZE3: dim_size_ff[3] <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         trs_pkg::REG_NUM_DIMS:  prdata = DataW'(num_dims_ff);
         trs_pkg::REG_BATCH_DIM: prdata = DataW'(batch_dim_ff);
         trs_pkg::REG_SEQ_DIM:   prdata = DataW'(seq_dim_ff);
         trs_pkg::REG_DIM_SIZE0: prdata = DataW'(dim_size_ff[0]);
         trs_pkg::REG_DIM_SIZE1: prdata = DataW'(dim_size_ff[1]);
         trs_pkg::REG_DIM_SIZE2: prdata = DataW'(dim_size_ff[2]);
         trs_pkg::REG_DIM_SIZE3: prdata = DataW'(dim_size_ff[3]);
         default:                prdata = '0;
      endcase
   end

   assign cfg.num_dims  = num_dims_ff;
   assign cfg.batch_dim = batch_dim_ff;
   assign cfg.seq_dim   = seq_dim_ff;
   assign cfg.dim_size  = dim_size_ff;

endmodule

// ===== rtl/trs_checker.sv =====
module trs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [trs_pkg::DestWidth-1:0]     rsp_dest_index,
   input logic [trs_pkg::ValueWidth-1:0]    rsp_out_value,
   input logic                              rsp_last,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [trs_pkg::AddrWidth-1:0]     paddr,
   input logic [trs_pkg::DataWidth-1:0]     pwdata,
   input logic [trs_pkg::DataWidth-1:0]     prdata
);

   logic [trs_pkg::AddrWidth-1:0] dim0_addr;

   assign dim0_addr = {trs_pkg::REG_DIM_SIZE0, 2'b00};

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_index)
         && $stable(rsp_out_value) && $stable(rsp_last))
      else $error("response word changed while stalled");

   // Leave reset with an empty pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // Backpressure only when the response side is stalled with a word
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

   // Read back a size just written, masked to its width
   a_dim_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr == dim0_addr)
         ##1 (psel && penable && !pwrite && paddr == dim0_addr)
      |-> prdata == {23'd0, $past(pwdata[8:0])})
      else $error("size register read back wrong value");

endmodule

bind tensor_reverse_sequence_remap trs_checker u_checker (.*);

// ===== tb/trs_remap_checker.sv =====
`timescale 1ns / 100ps

module trs_remap_checker (
   input  logic                               clock,
   input  logic                               reset,
   // request channel, observed
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_command,
   input  logic [trs_pkg::BatchIdxWidth-1:0]  req_batch_index,
   input  logic [trs_pkg::LenWidth-1:0]       req_seq_length,
   input  logic [trs_pkg::ValueWidth-1:0]     req_elem_value,
   // response channel, observed
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [trs_pkg::DestWidth-1:0]      rsp_dest_index,
   input  logic [trs_pkg::ValueWidth-1:0]     rsp_out_value,
   input  logic                               rsp_last,
   // configuration port, observed
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [trs_pkg::AddrWidth-1:0]      paddr,
   input  logic [trs_pkg::DataWidth-1:0]      pwdata,
   input  logic [trs_pkg::DataWidth-1:0]      prdata,
   input  logic                               pready,
   // status towards the top
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 results_checked,
   output int                                 tensors_seen
);

   import trs_pkg::*;

   localparam int unsigned TableDepth = 256;
   localparam int unsigned MaxDim     = 256;

   typedef struct packed {
      logic [DestWidth-1:0]  dest;
      logic [ValueWidth-1:0] value;
      logic                  last;
   } remap_word_type;

   // expected response words, oldest first
   remap_word_type owed_words [$];

   // shadow of the configuration, the length table and the coordinate counters
   logic [NumDimsWidth-1:0] num_dims;
   logic [AxisWidth-1:0]    batch_dim;
   logic [AxisWidth-1:0]    seq_dim;
   dim_type                 dim_size [NumAxes];
   logic [LenWidth-1:0]     len_table [TableDepth];
   int unsigned             coord [NumAxes];

   int err_n     = 0;
   int checked_n = 0;
   int tensor_n  = 0;

   // effective size of one axis: unused axes and size zero act as one
   function automatic int unsigned axis_extent(input int unsigned ax, input int unsigned nd);
      if (ax >= nd) return 1;
      if (dim_size[ax] == '0) return 1;
      if (dim_size[ax] > MaxDim) return MaxDim;
      return dim_size[ax];
   endfunction

   // work out the destination of the current element, then advance the counters
   function automatic remap_word_type remap_element(input logic [ValueWidth-1:0] v);
      int unsigned nd;
      int unsigned ext [NumAxes];
      int unsigned pos [NumAxes];
      int unsigned b;
      int unsigned span;
      logic [63:0] stride;
      logic [63:0] dest;
      bit          carry;
      remap_word_type w;
      nd = (num_dims < MinDims) ? MinDims : ((num_dims > MaxDims) ? MaxDims : num_dims);
      for (int ax = 0; ax < NumAxes; ax++) begin
         ext[ax] = axis_extent(ax, nd);
         pos[ax] = coord[ax];
      end
      // mirror the leading span of the sequence axis for this batch
      if (seq_dim < nd) begin
         b = (batch_dim < nd) ? pos[batch_dim] : 0;
         span = (b < TableDepth) ? len_table[b] : 0;
         if (span > ext[seq_dim]) span = ext[seq_dim];
         if (pos[seq_dim] < span) pos[seq_dim] = span - 1 - pos[seq_dim];
      end
      dest   = '0;
      stride = 64'd1;
      for (int ax = 0; ax < NumAxes; ax++) begin
         dest   = dest + 64'(pos[ax]) * stride;
         stride = stride * 64'(ext[ax]);
      end
      // advance with carry; a counter at or past its last coordinate wraps
      carry = 1'b1;
      for (int ax = 0; ax < NumAxes; ax++) begin
         if (carry) begin
            if (coord[ax] >= ext[ax] - 1) begin
               coord[ax] = 0;
            end else begin
               coord[ax] = coord[ax] + 1;
               carry = 1'b0;
            end
         end
      end
      w.dest  = dest[DestWidth-1:0];
      w.value = v;
      w.last  = carry;
      return w;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         err_n++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      remap_word_type w;
      logic [31:0] want;
      bit          known;
      if (reset) begin
         num_dims  = NumDimsReset;
         batch_dim = BatchDimReset;
         seq_dim   = SeqDimReset;
         for (int ax = 0; ax < NumAxes; ax++) begin
            dim_size[ax] = DimSizeReset;
            coord[ax]    = 0;
         end
         owed_words.delete();
      end else begin
         // track register writes, check read data
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[4:2])
                  REG_NUM_DIMS:  num_dims    = pwdata[NumDimsWidth-1:0];
                  REG_BATCH_DIM: batch_dim   = pwdata[AxisWidth-1:0];
                  REG_SEQ_DIM:   seq_dim     = pwdata[AxisWidth-1:0];
                  REG_DIM_SIZE0: dim_size[0] = pwdata[DimWidth-1:0];
                  REG_DIM_SIZE1: dim_size[1] = pwdata[DimWidth-1:0];
                  REG_DIM_SIZE2: dim_size[2] = pwdata[DimWidth-1:0];
                  REG_DIM_SIZE3: dim_size[3] = pwdata[DimWidth-1:0];
                  default: ;
               endcase
            end else begin
               known = 1'b1;
               want  = '0;
               case (paddr[4:2])
                  REG_NUM_DIMS:  want = 32'(num_dims);
                  REG_BATCH_DIM: want = 32'(batch_dim);
                  REG_SEQ_DIM:   want = 32'(seq_dim);
                  REG_DIM_SIZE0: want = 32'(dim_size[0]);
                  REG_DIM_SIZE1: want = 32'(dim_size[1]);
                  REG_DIM_SIZE2: want = 32'(dim_size[2]);
                  REG_DIM_SIZE3: want = 32'(dim_size[3]);
                  default:       known = 1'b0;
               endcase
               if (known) check_field("prdata", want, prdata);
            end
         end
         // compare each accepted response word with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (owed_words.size() == 0) begin
               err_n++;
               $display({"%0t ns: unexpected response, expected none, ",
                         "actual dest %h value %h last %b"},
                        $time, rsp_dest_index, rsp_out_value, rsp_last);
            end else begin
               w = owed_words.pop_front();
               check_field("dest_index", 32'(w.dest), 32'(rsp_dest_index));
               check_field("out_value", 32'(w.value), 32'(rsp_out_value));
               check_field("last", 32'(w.last), 32'(rsp_last));
               checked_n++;
               if (w.last) tensor_n++;
            end
         end
         // apply each accepted request word to the shadow state
         if (req_valid && req_ready) begin
            if (req_command == CMD_STORE_LEN) begin
               len_table[req_batch_index] = req_seq_length;
            end else begin
               owed_words.push_back(remap_element(req_elem_value));
            end
         end
      end
      error_count     <= err_n;
      pending_count   <= owed_words.size();
      results_checked <= checked_n;
      tensors_seen    <= tensor_n;
   end

endmodule

// ===== tb/tb_tensor_reverse_sequence_remap.sv =====
`timescale 1ns / 100ps

module tb_tensor_reverse_sequence_remap;

   import trs_pkg::*;

   localparam int unsigned NumRegs     = 7;
   localparam int unsigned RandomWords = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic                     req_command     = 1'b0;
   logic [BatchIdxWidth-1:0] req_batch_index = '0;
   logic [LenWidth-1:0]      req_seq_length  = '0;
   logic [ValueWidth-1:0]    req_elem_value  = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DestWidth-1:0]     rsp_dest_index;
   logic [ValueWidth-1:0]    rsp_out_value;
   logic                     rsp_last;

   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [AddrWidth-1:0]     paddr   = '0;
   logic [DataWidth-1:0]     pwdata  = '0;
   logic [DataWidth-1:0]     prdata;
   logic                     pready;

   int error_count;
   int pending_count;
   int results_checked;
   int tensors_seen;

   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int rsp_hold  = 0;

   int n_words  = 0;
   int n_stores = 0;
   int n_elems  = 0;
   int n_cfgs   = 0;

   logic [DimWidth-1:0] cfg_raw [NumRegs];

   tensor_reverse_sequence_remap dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_batch_index (req_batch_index),
      .req_seq_length  (req_seq_length),
      .req_elem_value  (req_elem_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_out_value   (rsp_out_value),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   trs_remap_checker remap_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_batch_index (req_batch_index),
      .req_seq_length  (req_seq_length),
      .req_elem_value  (req_elem_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_out_value   (rsp_out_value),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .tensors_seen    (tensors_seen)
   );

   always #5 clock = ~clock;

   // give up on a hung run
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   // idle length: mostly short, a few long
   function automatic int unsigned stall_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // register value for an effective size, using the aliases zero and above 256
   function automatic logic [DimWidth-1:0] raw_dim(input int unsigned eff);
      if (eff == 1) return DimWidth'($urandom_range(0, 1));
      if (eff == 256) return DimWidth'($urandom_range(256, 511));
      return DimWidth'(eff);
   endfunction

   // length for a batch, mostly around the sequence size
   function automatic logic [LenWidth-1:0] pick_len(input int unsigned ssize);
      int unsigned top;
      top = (ssize + 1 > 256) ? 256 : ssize + 1;
      if ($urandom_range(0, 9) == 0) return LenWidth'($urandom_range(0, 256));
      return LenWidth'($urandom_range(0, top));
   endfunction

   function automatic logic [31:0] reg_mask(input reg_index_type idx);
      case (idx) inside
         REG_NUM_DIMS:               return (32'd1 << NumDimsWidth) - 1;
         REG_BATCH_DIM, REG_SEQ_DIM: return (32'd1 << AxisWidth) - 1;
         default:                    return (32'd1 << DimWidth) - 1;
      endcase
   endfunction

   // drop or raise the receiver's ready, once per edge
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (!rsp_quiet && $urandom_range(0, 99) < 25) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= stall_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // offer one request word and hold it until accepted
   task automatic send_word(input command_type cmd, input logic [BatchIdxWidth-1:0] bi,
                            input logic [LenWidth-1:0] len, input logic [ValueWidth-1:0] v);
      if (!req_quiet && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat (stall_len()) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_batch_index <= bi;
      req_seq_length  <= len;
      req_elem_value  <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_words++;
      if (cmd == CMD_STORE_LEN) n_stores++;
      else n_elems++;
   endtask

   task automatic store_len(input int unsigned bi, input logic [LenWidth-1:0] len);
      send_word(CMD_STORE_LEN, BatchIdxWidth'(bi), len, ValueWidth'($urandom()));
   endtask

   task automatic send_elem(input logic [ValueWidth-1:0] v);
      send_word(CMD_ELEMENT, BatchIdxWidth'($urandom()), LenWidth'($urandom()), v);
   endtask

   // one APB transfer: setup, access, then idle
   task automatic csr_access(input reg_index_type idx, input logic wr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_regs();
      reg_index_type idx;
      idx = idx.first();
      do begin
         csr_access(idx, 1'b0, $urandom());
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   // stop offering, wait for every owed response, then let stores settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   // drain, write every register with junk above its width, read them back
   task automatic apply_config(input int unsigned nd_raw, input int unsigned ba,
                               input int unsigned sa, input logic [DimWidth-1:0] d0,
                               input logic [DimWidth-1:0] d1, input logic [DimWidth-1:0] d2,
                               input logic [DimWidth-1:0] d3);
      reg_index_type idx;
      logic [31:0]   data;
      drain_pipeline();
      cfg_raw[REG_NUM_DIMS]  = DimWidth'(nd_raw & 7);
      cfg_raw[REG_BATCH_DIM] = DimWidth'(ba & 3);
      cfg_raw[REG_SEQ_DIM]   = DimWidth'(sa & 3);
      cfg_raw[REG_DIM_SIZE0] = d0;
      cfg_raw[REG_DIM_SIZE1] = d1;
      cfg_raw[REG_DIM_SIZE2] = d2;
      cfg_raw[REG_DIM_SIZE3] = d3;
      idx = idx.first();
      do begin
         data = ($urandom() & ~reg_mask(idx)) | 32'(cfg_raw[idx]);
         csr_access(idx, 1'b1, data);
         idx = idx.next();
      end while (idx != idx.first());
      read_all_regs();
      n_cfgs++;
   endtask

   // random shape, lengths for every batch in use, then whole tensors
   task automatic run_tensor_phase();
      int unsigned nd, nd_raw, ba, sa, big, count, bsize, ssize, ntens, stop_at;
      int unsigned ext [NumAxes];
      logic [DimWidth-1:0] raw [NumAxes];
      nd = $urandom_range(2, 4);
      nd_raw = nd;
      if (nd == 2 && $urandom_range(0, 4) == 0) nd_raw = $urandom_range(0, 1);
      if (nd == 4 && $urandom_range(0, 4) == 0) nd_raw = $urandom_range(5, 7);
      ba = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, nd - 1);
      sa = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, nd - 1);
      for (int ax = 0; ax < NumAxes; ax++) ext[ax] = (ax < nd) ? $urandom_range(1, 5) : 1;
      // now and then one long axis, the rest flat
      if ($urandom_range(0, 6) == 0) begin
         big = $urandom_range(0, nd - 1);
         for (int ax = 0; ax < NumAxes; ax++) ext[ax] = 1;
         ext[big] = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(6, 60);
      end
      for (int ax = 0; ax < NumAxes; ax++)
         raw[ax] = (ax < nd) ? raw_dim(ext[ax]) : DimWidth'($urandom_range(0, 511));
      apply_config(nd_raw, ba, sa, raw[0], raw[1], raw[2], raw[3]);
      req_quiet = ($urandom_range(0, 3) == 0);
      rsp_quiet = ($urandom_range(0, 3) == 0);
      count = 1;
      for (int ax = 0; ax < NumAxes; ax++) count = count * ext[ax];
      bsize = (ba < nd) ? ext[ba] : 1;
      ssize = (sa < nd) ? ext[sa] : 1;
      for (int b = 0; b < bsize; b++) store_len(b, pick_len(ssize));
      ntens = (count > 64) ? 1 : $urandom_range(1, 3);
      stop_at = count * ntens;
      // cut some phases short so the next setting meets counters mid-tensor
      if ($urandom_range(0, 6) == 0) stop_at = $urandom_range(1, stop_at);
      for (int k = 0; k < stop_at; k++) begin
         if ($urandom_range(0, 19) == 0)
            store_len($urandom_range(0, 255), LenWidth'($urandom_range(0, 256)));
         send_elem(ValueWidth'($urandom()));
      end
   endtask

   // walk the outer counters up by widening axes mid-tensor, then wrap them all
   task automatic run_counter_climb();
      int unsigned ba, sa, steps;
      int unsigned ext [NumAxes];
      ba = $urandom_range(0, 3);
      sa = $urandom_range(0, 3);
      for (int k = 0; k < 8; k++)
         store_len($urandom_range(0, 255), LenWidth'($urandom_range(0, 256)));
      for (int st = 0; st < NumAxes; st++) begin
         for (int ax = 0; ax < NumAxes; ax++) ext[ax] = (ax >= NumAxes - 1 - st) ? 256 : 1;
         apply_config(4, ba, sa, raw_dim(ext[0]), raw_dim(ext[1]), raw_dim(ext[2]),
                      raw_dim(ext[3]));
         steps = (st < NumAxes - 1) ? $urandom_range(1, 60) : $urandom_range(1, 8);
         for (int k = 0; k < steps; k++) send_elem(ValueWidth'($urandom()));
      end
      apply_config(4, ba, sa, raw_dim(1), raw_dim(1), raw_dim(1), raw_dim(1));
      send_elem(ValueWidth'($urandom()));
   endtask

   initial begin
      int phase;
      int random_end;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset values of every register
      read_all_regs();

      // fill the whole length table so no element meets an unwritten entry
      for (int b = 0; b < 256; b++) store_len(b, LenWidth'($urandom_range(0, 256)));

      // two axes, batch outer: full-length clamped reversal and a partial one
      apply_config(2, 1, 0, 4, 2, 0, 0);
      store_len(0, 256);
      store_len(1, 3);
      send_elem('0);
      send_elem('1);
      for (int k = 0; k < 6; k++) send_elem(ValueWidth'($urandom()));

      // batch and sequence on the same axis
      apply_config(3, 1, 1, 1, 3, 1, 0);
      store_len(0, 0);
      store_len(1, 2);
      store_len(2, 3);
      for (int k = 0; k < 3; k++) send_elem(ValueWidth'($urandom()));

      // dimension count below two, sequence axis unused, size zero
      apply_config(1, 0, 3, 0, 2, 0, 0);
      send_elem('1);
      send_elem('0);

      // batch axis unused, oversize axis, then shrink mid-tensor so all counters wrap
      apply_config(3, 3, 0, 511, 1, 1, 9);
      store_len(0, 3);
      for (int k = 0; k < 4; k++) send_elem(ValueWidth'($urandom()));
      apply_config(5, 3, 0, 0, 1, 0, 1);
      send_elem(ValueWidth'($urandom()));

      // random phases, with an occasional counter climb
      random_end = n_words + RandomWords;
      phase = 0;
      while (n_words < random_end) begin
         if (phase % 12 == 6) run_counter_climb();
         else run_tensor_phase();
         phase++;
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;

      // wait for every owed response, then watch for strays
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d length stores and %0d elements under %0d register settings",
               n_stores, n_elems, n_cfgs);
      $display("Checked %0d responses over %0d completed tensors, with wraps and clamps",
               results_checked, tensors_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
